@@ sv/serial_line_editor_assert.svh @@
// Assertion macros used by the serial line editor sequencer.
`ifndef SERIAL_LINE_EDITOR_ASSERT_SVH
`define SERIAL_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLE_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLE_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ sv/sle_pkg.sv @@
// Shared constants and types of the serial line editor.
package sle_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  localparam logic [5:0] MAX_LEN_RESET = 6'd30;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ sv/sle_line_ram.sv @@
// Line store: one write port and one registered read port.
module sle_line_ram (
  input  logic              clk,
  input  sle_pkg::ram_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [sle_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read data holds between reads, so the sequencer may wait on a stalled output.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ sv/sle_ctrl.sv @@
// Editing sequencer: takes bytes, updates the line store and produces results.
`include "serial_line_editor_assert.svh"

module sle_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [7:0]                   in_byte,
  output logic                         in_ready,
  input  logic                         cfg_valid,
  input  logic [5:0]                   cfg_max_len,
  output sle_pkg::ram_req_t            ram_req,
  input  logic [7:0]                   ram_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_byte,
  output logic [sle_pkg::CNT_W-1:0]    out_len,
  output logic                         out_esc,
  output logic                         out_last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BS1  = 4'd1;
  localparam logic [3:0] S_BS2  = 4'd2;
  localparam logic [3:0] S_BS3  = 4'd3;
  localparam logic [3:0] S_ECHO = 4'd4;
  localparam logic [3:0] S_LF   = 4'd5;
  localparam logic [3:0] S_BYTE = 4'd6;
  localparam logic [3:0] S_END  = 4'd7;

  localparam logic [sle_pkg::CNT_W-1:0] DEPTH_CNT = sle_pkg::CNT_W'(sle_pkg::BUF_DEPTH);

  logic [3:0]                  state_r, state_nxt;
  logic [5:0]                  max_len_r;
  logic [sle_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [sle_pkg::CNT_W-1:0]   len_r, len_nxt;
  logic [sle_pkg::ADDR_W-1:0]  idx_r, idx_nxt;
  logic [7:0]                  c_r, c_nxt;
  logic                        end_r, end_nxt;
  logic                        esc_r, esc_nxt;
  logic                        cr_r, cr_nxt;

  logic                        out_valid_r;
  logic [1:0]                  out_kind_r;
  logic [7:0]                  out_byte_r;
  logic [sle_pkg::CNT_W-1:0]   out_len_r;
  logic                        out_esc_r;
  logic                        out_last_r;

  logic                        load_ok;
  logic                        emit;
  logic [1:0]                  e_kind;
  logic [7:0]                  e_byte;
  logic [sle_pkg::CNT_W-1:0]   e_len;
  logic                        e_esc;
  logic                        e_last;

  logic [sle_pkg::CNT_W-1:0]   limit;
  logic [7:0]                  c_eff;
  logic                        is_bs;
  logic                        do_store;
  logic [sle_pkg::CNT_W-1:0]   fill_new;
  logic                        ends_line;
  logic [sle_pkg::CNT_W-1:0]   idx_inc;

  assign limit   = (int'(max_len_r) < sle_pkg::BUF_DEPTH) ? sle_pkg::CNT_W'(max_len_r)
                                                          : DEPTH_CNT;
  assign c_eff   = (in_byte == sle_pkg::CH_DEL) ? sle_pkg::CH_BS : in_byte;
  assign is_bs   = (c_eff == sle_pkg::CH_BS);
  assign do_store = (c_eff >= sle_pkg::CH_SPACE) && (fill_r < DEPTH_CNT);
  assign fill_new = is_bs ? (fill_r - 1'b1) : (fill_r + sle_pkg::CNT_W'(do_store));
  assign ends_line = (c_eff == sle_pkg::CH_ESC) || (c_eff == sle_pkg::CH_LF) ||
                     (c_eff == sle_pkg::CH_CR) || (fill_new >= limit);
  assign idx_inc = sle_pkg::CNT_W'(idx_r) + 1'b1;

  assign in_ready = (state_r == S_IDLE);
  assign load_ok  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    c_nxt     = c_r;
    end_nxt   = end_r;
    esc_nxt   = esc_r;
    cr_nxt    = cr_r;
    emit      = 1'b0;
    e_kind    = sle_pkg::KIND_ECHO;
    e_byte    = c_r;
    e_len     = '0;
    e_esc     = 1'b0;
    e_last    = 1'b0;
    ram_req   = '0;
    ram_req.waddr = fill_r[sle_pkg::ADDR_W-1:0];
    ram_req.wdata = c_eff;

    case (state_r)
      S_IDLE: begin
        // An empty backspace is taken and produces nothing.
        if (in_valid && !(is_bs && fill_r == '0)) begin
          ram_req.we = do_store;
          c_nxt   = c_eff;
          end_nxt = ends_line;
          esc_nxt = (c_eff == sle_pkg::CH_ESC);
          cr_nxt  = (c_eff == sle_pkg::CH_CR);
          len_nxt = (c_eff == sle_pkg::CH_ESC) ? '0 : fill_new;
          fill_nxt = ends_line ? '0 : fill_new;
          state_nxt = is_bs ? S_BS1 : S_ECHO;
        end
      end
      S_BS1, S_BS2: begin
        emit   = load_ok;
        e_byte = (state_r == S_BS1) ? sle_pkg::CH_BS : sle_pkg::CH_SPACE;
        if (load_ok) begin
          state_nxt = (state_r == S_BS1) ? S_BS2 : S_BS3;
        end
      end
      S_BS3, S_ECHO, S_LF: begin
        emit   = load_ok;
        e_byte = (state_r == S_BS3) ? sle_pkg::CH_BS :
                 (state_r == S_LF)  ? sle_pkg::CH_LF : c_r;
        e_last = !end_r;
        if (load_ok) begin
          if (!end_r) begin
            state_nxt = S_IDLE;
          end else if (esc_r) begin
            state_nxt = S_END;
          end else if (cr_r && state_r != S_LF) begin
            state_nxt = S_LF;
          end else if (len_r != '0) begin
            // Fetch the first line byte while this echo is handed over.
            ram_req.re    = 1'b1;
            ram_req.raddr = '0;
            idx_nxt   = '0;
            state_nxt = S_BYTE;
          end else begin
            state_nxt = S_END;
          end
        end
      end
      S_BYTE: begin
        emit   = load_ok;
        e_kind = sle_pkg::KIND_BYTE;
        e_byte = ram_rdata;
        if (load_ok) begin
          if (idx_inc < len_r) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_inc[sle_pkg::ADDR_W-1:0];
            idx_nxt       = idx_inc[sle_pkg::ADDR_W-1:0];
          end else begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        emit   = load_ok;
        e_kind = sle_pkg::KIND_END;
        e_byte = '0;
        e_len  = len_r;
        e_esc  = esc_r;
        e_last = 1'b1;
        if (load_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      max_len_r   <= sle_pkg::MAX_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (cfg_valid) begin
        max_len_r <= cfg_max_len;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    idx_r <= idx_nxt;
    c_r   <= c_nxt;
    end_r <= end_nxt;
    esc_r <= esc_nxt;
    cr_r  <= cr_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_byte_r <= e_byte;
      out_len_r  <= e_len;
      out_esc_r  <= e_esc;
      out_last_r <= e_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_len   = out_len_r;
  assign out_esc   = out_esc_r;
  assign out_last  = out_last_r;

  `SLE_ASSERT_NOW(a_fill_range, 1'b1, fill_r <= DEPTH_CNT, "fill count beyond store depth")
  `SLE_ASSERT_NOW(a_write_idle, ram_req.we, state_r == S_IDLE, "store written outside idle")
  `SLE_ASSERT_NOW(a_dump_index, state_r == S_BYTE, sle_pkg::CNT_W'(idx_r) < len_r,
                  "line read index past length")
  `SLE_ASSERT_NEXT(a_last_idle, emit && e_last, state_r == S_IDLE,
                   "final result loaded but sequencer not idle")

endmodule

@@ sv/serial_line_editor.sv @@
// Top level of the serial line editor: stream ports, line store and sequencer.
//
//   Channel  Ports           Direction  Contents
//   input    in_t*           in         tdata[7:0] received byte
//   result   out_t*          out        tdata echo/line byte, length, escape; tuser kind
//   config   cfg_*           in         cfg_data[5:0] max_len, always ready
//
// One byte is taken at a time; once it is accepted, its results follow in order (echo,
// backspace echo of three, LF, one per stored byte, end marker), and no new byte is
// taken until the last of them is loaded into the output register.
// Reset (rst_n low, synchronous) empties the line and sets max_len to 30; the store
// itself is not cleared. A stalled result holds the sequencer; a new byte is taken
// while the last result of the previous one is still waiting in the output register.
module serial_line_editor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [13:8] line_length, [14] escaped
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data    // [5:0] max_len
);

  sle_pkg::ram_req_t          ram_req;
  logic [7:0]                 ram_rdata;
  logic [7:0]                 res_byte;
  logic [sle_pkg::CNT_W-1:0]  res_len;
  logic                       res_esc;

  assign cfg_ready = 1'b1;

  sle_line_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  sle_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_byte     (in_tdata),
    .in_ready    (in_tready),
    .cfg_valid   (cfg_valid),
    .cfg_max_len (cfg_data),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_tuser),
    .out_byte    (res_byte),
    .out_len     (res_len),
    .out_esc     (res_esc),
    .out_last    (out_tlast)
  );

  assign out_tdata = {1'b0, res_esc, 6'(res_len), res_byte};

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the serial line editor: stream stimulus and a line scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TARGET_ITEMS    = 250;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [5:0] len;
    logic       esc;
    logic       last;
  } line_result_t;

  // Tracks the line being edited and queues the echoes per byte, and the line bytes and end marker when a line closes.
  class line_scoreboard;
    logic [7:0]   held [sle_pkg::BUF_DEPTH];
    int unsigned  fill;
    logic [5:0]   max_len;
    line_result_t pending[$];
    int unsigned  errors;

    function new();
      fill    = 0;
      max_len = sle_pkg::MAX_LEN_RESET;
      errors  = 0;
    endfunction

    function void set_max_len(logic [5:0] value);
      max_len = value;
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] data, logic [5:0] len, logic esc);
      pending.push_back(line_result_t'{kind, data, len, esc, 1'b0});
    endfunction

    function int unsigned note_input(logic [7:0] rx);
      logic [7:0]   c;
      int unsigned  limit;
      int unsigned  len;
      int unsigned  first;
      line_result_t tail;
      first = pending.size();
      c     = (rx == sle_pkg::CH_DEL) ? sle_pkg::CH_BS : rx;
      limit = (max_len < sle_pkg::BUF_DEPTH) ? max_len : sle_pkg::BUF_DEPTH;
      if (c == sle_pkg::CH_BS) begin
        // Rubbing out on an empty line is silent.
        if (fill == 0) return 0;
        fill--;
        add_result(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 6'd0, 1'b0);
        add_result(sle_pkg::KIND_ECHO, sle_pkg::CH_SPACE, 6'd0, 1'b0);
        add_result(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 6'd0, 1'b0);
      end else begin
        if (c >= sle_pkg::CH_SPACE && fill < sle_pkg::BUF_DEPTH) begin
          held[fill] = c;
          fill++;
        end
        add_result(sle_pkg::KIND_ECHO, c, 6'd0, 1'b0);
      end
      if (c == sle_pkg::CH_ESC) begin
        fill = 0;
        add_result(sle_pkg::KIND_END, 8'd0, 6'd0, 1'b1);
      end else if (c == sle_pkg::CH_LF || c == sle_pkg::CH_CR || fill >= limit) begin
        len = fill;
        if (c == sle_pkg::CH_CR) add_result(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 6'd0, 1'b0);
        for (int unsigned i = 0; i < len; i++)
          add_result(sle_pkg::KIND_BYTE, held[i], 6'd0, 1'b0);
        add_result(sle_pkg::KIND_END, 8'd0, len[5:0], 1'b0);
        fill = 0;
      end
      tail = pending.pop_back();
      tail.last = 1'b1;
      pending.push_back(tail);
      return pending.size() - first;
    endfunction

    function void field_mismatch(string name, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    endfunction

    function void check_result(line_result_t got);
      line_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d data 0x%0h",
                 $time, got.kind, got.data);
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) field_mismatch("out_kind", 16'(want.kind), 16'(got.kind));
      if (got.data !== want.data) field_mismatch("data_byte", 16'(want.data), 16'(got.data));
      if (got.len !== want.len) field_mismatch("line_length", 16'(want.len), 16'(got.len));
      if (got.esc !== want.esc) field_mismatch("escaped", 16'(want.esc), 16'(got.esc));
      if (got.last !== want.last) field_mismatch("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;

  line_scoreboard board = new();
  bit             steady;
  bit             hold_off_req;
  int unsigned    answered_items;

  serial_line_editor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    if (board.note_input(b) != 0) answered_items++;
  endtask

  task automatic sender_gap(int unsigned n);
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tdata  = 8'($urandom_range(0, 255));
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic pace();
    if (!steady && $urandom_range(0, 3) == 0) sender_gap(pick_gap());
  endtask

  // Waits until every queued result has come out, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(logic [5:0] value);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    board.set_max_len(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One typed line: mostly printable bytes with some rubbing out, then a random terminator or none.
  task automatic type_line();
    int unsigned target;
    int unsigned r;
    target = $urandom_range(0, 36);
    for (int unsigned k = 0; k < target; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_byte(r < 4 ? sle_pkg::CH_DEL : sle_pkg::CH_BS);
      else if (r < 12) send_byte(8'($urandom_range(0, 31)));
      else send_byte(8'($urandom_range(32, 255)));
      pace();
    end
    r = $urandom_range(0, 9);
    if (r < 4) send_byte(sle_pkg::CH_CR);
    else if (r < 7) send_byte(sle_pkg::CH_LF);
    else if (r == 7) send_byte(sle_pkg::CH_ESC);
    pace();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(line_result_t'{out_tuser, out_tdata[7:0], out_tdata[13:8],
                                        out_tdata[14], out_tlast});
  end

  initial begin : receiver
    int unsigned gap;
    gap        = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // Long hold-off so the block backs up and stops taking input.
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_tready   = 1'b1;
      end else if (gap != 0) begin
        out_tready = 1'b0;
        gap--;
      end else begin
        out_tready = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) gap = pick_gap();
      end
    end
  end

  initial begin
    #40_000_000;
    $display("** serial_line_editor: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned segments;
    logic [5:0]  setting;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'd0;
    cfg_valid      = 1'b0;
    cfg_data       = 6'd0;
    steady         = 1'b0;
    hold_off_req   = 1'b0;
    answered_items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Printable extremes, a control byte, both rub-out codes, then CR.
    send_byte(8'h41);
    send_byte(8'h7e);
    send_byte(sle_pkg::CH_SPACE);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(sle_pkg::CH_BS);
    send_byte(sle_pkg::CH_DEL);
    send_byte(sle_pkg::CH_CR);
    // Rub-out on an empty line, then a line closed by LF.
    send_byte(sle_pkg::CH_BS);
    send_byte(sle_pkg::CH_DEL);
    send_byte(8'h5a);
    send_byte(sle_pkg::CH_LF);
    // Escape with text held.
    send_byte(8'h71);
    send_byte(sle_pkg::CH_ESC);
    // Empty line.
    send_byte(8'h1f);
    send_byte(sle_pkg::CH_LF);
    // Line full at one byte, then the zero limit.
    write_max_len(6'd1);
    send_byte(8'h61);
    write_max_len(6'd0);
    send_byte(8'h05);
    send_byte(8'h62);
    send_byte(sle_pkg::CH_BS);
    write_max_len(6'd2);
    send_byte(8'h63);
    send_byte(8'h64);

    phase = 0;
    while (answered_items < TARGET_ITEMS) begin
      case (phase)
        0: setting = 6'd20;
        1: setting = 6'd32;
        2: setting = 6'd1;
        3: setting = 6'd0;
        4: setting = 6'd31;
        5: setting = 6'd63;
        default: setting = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 2))
                                                         : 6'($urandom_range(3, 63));
      endcase
      write_max_len(setting);
      steady = (phase % 4 == 1);
      if (phase == 0) begin
        hold_off_req = 1'b1;
        for (int unsigned k = 0; k < 45; k++)
          send_byte((k % 15 == 14) ? sle_pkg::CH_LF : 8'($urandom_range(32, 126)));
      end
      segments = $urandom_range(2, 5);
      for (int unsigned s = 0; s < segments && answered_items < TARGET_ITEMS; s++) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 5)) begin
            send_byte(8'($urandom_range(0, 255)));
            pace();
          end
        end else begin
          type_line();
        end
      end
      phase++;
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** serial_line_editor: PASSED **");
    end else begin
      $display("** serial_line_editor: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sle_pkg.sv
sv/sle_line_ram.sv
sv/sle_ctrl.sv
sv/serial_line_editor.sv
tb/tb.sv
